[hdl/eia_pkg.sv]
// shared types and constants for the elliptic integral agm block
package eia_pkg;

  localparam int W = 64;
  localparam int PW = 2 * W;
  localparam logic [W-1:0] PI_HALF_Q28 = 64'h0000_0000_1921_FB54;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

  // configuration register indexes
  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_CONV_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_SQRT = 3'b010,
    OP_DIV  = 3'b100
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [W-1:0]  x;
    logic [W-1:0]  y;
    logic [PW-1:0] n;
    logic          sat32;
  } cmd_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] res;
  } rsp_t;

endpackage

[hdl/eia_unit.sv]
// shared iterative multiply, square root and divide unit
module eia_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  eia_pkg::cmd_t cmd,
  output eia_pkg::rsp_t rsp
);

  eia_pkg::op_t                op;
  logic                        busy;
  logic [6:0]                  cnt;
  logic [eia_pkg::PW-1:0]      acc;
  logic [eia_pkg::PW-1:0]      nsh;
  logic [eia_pkg::W-1:0]       x;
  logic [eia_pkg::W-1:0]       y;
  logic                        sat32;
  logic [63:0]                 prod;
  logic [1:0]                  psh;
  logic [66:0]                 rem;
  logic [eia_pkg::W-1:0]       root;
  logic [eia_pkg::W-1:0]       q;
  logic                        ovf;
  logic                        done;

  logic [31:0]                 xs;
  logic [31:0]                 ys;
  logic [66:0]                 sq_rem;
  logic [66:0]                 sq_trial;
  logic [eia_pkg::W-1:0]       sq_root;
  logic [66:0]                 sq_rem_next;
  logic [64:0]                 dv_r2;
  logic                        dv_ge;
  logic [eia_pkg::W-1:0]       dv_q;
  logic                        dv_ovf;
  logic [eia_pkg::W-1:0]       dv_max;

  always_comb begin
    xs = cnt[0] ? x[63:32] : x[31:0];
    ys = cnt[1] ? y[63:32] : y[31:0];
    sq_rem = {rem[64:0], nsh[127:126]};
    sq_trial = {1'b0, root, 2'b01};
    if (sq_rem >= sq_trial) begin
      sq_rem_next = sq_rem - sq_trial;
      sq_root = {root[62:0], 1'b1};
    end else begin
      sq_rem_next = sq_rem;
      sq_root = {root[62:0], 1'b0};
    end
    dv_r2 = {rem[63:0], nsh[127]};
    dv_ge = dv_r2 >= {1'b0, y};
    dv_q = {q[62:0], dv_ge};
    dv_ovf = ovf | q[63];
    dv_max = sat32 ? eia_pkg::OUT_MAX : eia_pkg::ALL_ONES;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      op <= eia_pkg::OP_MUL;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        op <= cmd.op;
        x <= cmd.x;
        y <= cmd.y;
        nsh <= cmd.n;
        sat32 <= cmd.sat32;
        acc <= '0;
        rem <= '0;
        root <= '0;
        q <= '0;
        ovf <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        unique case (op)
          eia_pkg::OP_MUL: begin
            if (cnt != 7'd0) begin
              acc <= acc + ({64'd0, prod} << {psh, 5'd0});
            end
            if (cnt != 7'd4) begin
              prod <= 64'(xs) * 64'(ys);
              psh <= 2'(cnt[0]) + 2'(cnt[1]);
            end else begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          eia_pkg::OP_SQRT: begin
            nsh <= nsh << 2;
            rem <= sq_rem_next;
            root <= sq_root;
            if (cnt == 7'd63) begin
              acc <= {64'd0, sq_root};
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          eia_pkg::OP_DIV: begin
            nsh <= nsh << 1;
            rem <= dv_ge ? 67'(dv_r2 - {1'b0, y}) : 67'(dv_r2);
            q <= dv_q;
            ovf <= dv_ovf;
            if (cnt == 7'd127) begin
              if (y == '0 || dv_ovf || dv_q > dv_max) begin
                acc <= {64'd0, dv_max};
              end else begin
                acc <= {64'd0, dv_q};
              end
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res = acc;

endmodule

[hdl/elliptic_integral_agm.sv]
// Complete elliptic integrals K(m) and E(m) by the arithmetic-geometric mean.
// One word in, one word out; the block takes one word at a time and is busy
// until its result is in the output register. All work runs on one shared
// unit for multiply, square root and divide. A word goes through setup (with
// more steps for negative m), the AGM iterations and the final divisions (two
// more for negative m); m of one or more skips the unit. The square root and
// divide loops take the bulk of the time.
module elliptic_integral_agm #(
  parameter int MAX_ITERATIONS = 16,
  parameter int FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // param_m
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // k_value, e_value
  output logic [1:0]  m_axis_tuser,   // k_infinite, not_converged
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int UP = FRAC_BITS >= 30 ? FRAC_BITS - 30 : 0;
  localparam int DN = FRAC_BITS < 30 ? 30 - FRAC_BITS : 0;
  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [5:0] MAX_IT = 6'(MAX_ITERATIONS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef enum logic [20:0] {
    SP_NMUL  = 21'h000001,
    SP_NDIV  = 21'h000002,
    SP_NMUL2 = 21'h000004,
    SP_NSQ   = 21'h000008,
    SP_BMUL  = 21'h000010,
    SP_BSQ   = 21'h000020,
    SP_CMUL  = 21'h000040,
    SP_CSQ   = 21'h000080,
    SP_SMUL  = 21'h000100,
    SP_LMUL  = 21'h000200,
    SP_LSQ   = 21'h000400,
    SP_TMUL  = 21'h000800,
    SP_QMUL  = 21'h001000,
    SP_KMUL  = 21'h002000,
    SP_KDIV  = 21'h004000,
    SP_KMUL2 = 21'h008000,
    SP_KDIV2 = 21'h010000,
    SP_EMUL  = 21'h020000,
    SP_EDIV  = 21'h040000,
    SP_EMUL2 = 21'h080000,
    SP_EDIV2 = 21'h100000
  } step_t;

  state_t state;
  step_t step;
  logic [4:0] iteration_limit;
  logic [30:0] converge_limit;
  logic neg;
  logic [63:0] da, den, sq, a, b, c, s, kv, ev;
  logic [127:0] p;
  logic [IW-1:0] it;
  logic k_inf, not_conv;
  logic [63:0] out_k, out_e;
  logic out_inf, out_nc;

  eia_pkg::cmd_t cmd;
  eia_pkg::rsp_t rsp;

  logic [63:0] in_int, mag_int, da_c, rest, term, term_sh, s_sum, a_avg, c_new;
  logic [5:0] lim6;
  logic [IW-1:0] lim;
  logic [31:0] mag32;

  eia_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_RUN),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  always_comb begin
    in_int = (64'(s_axis_tdata) << UP) >> DN;
    mag32 = 32'(-s_axis_tdata);
    mag_int = (64'(mag32) << UP) >> DN;
    da_c = da > ONE ? ONE : da;
    rest = s < ONE ? ONE - s : 64'd0;
    lim6 = ({1'b0, iteration_limit} > MAX_IT) ? MAX_IT : {1'b0, iteration_limit};
    lim = IW'(lim6);
    term = rsp.res[FRAC_BITS +: 64];
    term_sh = term > (eia_pkg::ALL_ONES >> it) ? eia_pkg::ALL_ONES : term << it;
    s_sum = s > eia_pkg::ALL_ONES - term_sh ? eia_pkg::ALL_ONES : s + term_sh;
    a_avg = (a >> 1) + (b >> 1) + 64'(a[0] & b[0]);
    c_new = a >= b ? (a - b) >> 1 : 64'd0;
  end

  always_comb begin
    cmd.op = eia_pkg::OP_MUL;
    cmd.x = '0;
    cmd.y = ONE;
    cmd.n = p;
    cmd.sat32 = 1'b1;
    unique case (step)
      SP_NMUL:  cmd.x = da;
      SP_NDIV: begin
        cmd.op = eia_pkg::OP_DIV;
        cmd.y = den;
        cmd.sat32 = 1'b0;
      end
      SP_NMUL2: cmd.x = den;
      SP_NSQ:   cmd.op = eia_pkg::OP_SQRT;
      SP_BMUL:  cmd.x = ONE - da_c;
      SP_BSQ:   cmd.op = eia_pkg::OP_SQRT;
      SP_CMUL:  cmd.x = da_c;
      SP_CSQ:   cmd.op = eia_pkg::OP_SQRT;
      SP_SMUL: begin
        cmd.x = c;
        cmd.y = c;
      end
      SP_LMUL: begin
        cmd.x = a;
        cmd.y = b;
      end
      SP_LSQ:   cmd.op = eia_pkg::OP_SQRT;
      SP_TMUL: begin
        cmd.x = c_new;
        cmd.y = c_new;
      end
      SP_QMUL: begin
        cmd.x = 64'(converge_limit);
        cmd.y = a;
      end
      SP_KMUL:  cmd.x = eia_pkg::PI_HALF_Q28;
      SP_KDIV: begin
        cmd.op = eia_pkg::OP_DIV;
        cmd.y = a;
        cmd.sat32 = !neg;
      end
      SP_KMUL2: cmd.x = kv;
      SP_KDIV2: begin
        cmd.op = eia_pkg::OP_DIV;
        cmd.y = sq;
      end
      SP_EMUL: begin
        cmd.x = eia_pkg::PI_HALF_Q28;
        cmd.y = rest;
      end
      SP_EDIV: begin
        cmd.op = eia_pkg::OP_DIV;
        cmd.y = a;
        cmd.sat32 = !neg;
      end
      SP_EMUL2: begin
        cmd.x = ev;
        cmd.y = sq;
      end
      SP_EDIV2: cmd.op = eia_pkg::OP_DIV;
      default: cmd.op = eia_pkg::OP_MUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= SP_BMUL;
      iteration_limit <= 5'd16;
      converge_limit <= 31'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == eia_pkg::CFG_CONV_LIMIT) begin
          converge_limit <= cfg_data;
        end else begin
          iteration_limit <= cfg_data[4:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            neg <= s_axis_tdata[31];
            a <= ONE;
            sq <= ONE;
            ev <= '0;
            not_conv <= 1'b0;
            if (!s_axis_tdata[31] && s_axis_tdata[30]) begin
              kv <= eia_pkg::OUT_MAX;
              k_inf <= 1'b1;
              state <= ST_DONE;
            end else if (s_axis_tdata[31]) begin
              kv <= '0;
              k_inf <= 1'b0;
              da <= mag_int;
              den <= ONE + mag_int;
              step <= SP_NMUL;
              state <= ST_RUN;
            end else begin
              kv <= '0;
              k_inf <= 1'b0;
              da <= in_int;
              step <= SP_BMUL;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: state <= ST_WAIT;
        ST_WAIT: begin
          if (rsp.done) begin
            p <= rsp.res;
            state <= ST_RUN;
            unique case (step)
              SP_NMUL:  step <= SP_NDIV;
              SP_NDIV: begin
                da <= rsp.res[63:0];
                step <= SP_NMUL2;
              end
              SP_NMUL2: step <= SP_NSQ;
              SP_NSQ: begin
                sq <= rsp.res[63:0];
                step <= SP_BMUL;
              end
              SP_BMUL:  step <= SP_BSQ;
              SP_BSQ: begin
                b <= rsp.res[63:0];
                step <= SP_CMUL;
              end
              SP_CMUL:  step <= SP_CSQ;
              SP_CSQ: begin
                c <= rsp.res[63:0];
                step <= SP_SMUL;
              end
              SP_SMUL: begin
                s <= rsp.res[FRAC_BITS + 1 +: 64];
                it <= '0;
                if (lim == '0) begin
                  not_conv <= 1'b1;
                  state <= ST_DONE;
                end else begin
                  step <= SP_LMUL;
                end
              end
              SP_LMUL:  step <= SP_LSQ;
              SP_LSQ: begin
                step <= SP_TMUL;
              end
              SP_TMUL: begin
                s <= s_sum;
                c <= c_new;
                b <= p[63:0];
                a <= a_avg;
                step <= SP_QMUL;
              end
              SP_QMUL: begin
                if ((128'(c) << 30) < rsp.res) begin
                  step <= SP_KMUL;
                end else if (it + IW'(1) == lim) begin
                  not_conv <= 1'b1;
                  state <= ST_DONE;
                end else begin
                  it <= it + IW'(1);
                  step <= SP_LMUL;
                end
              end
              SP_KMUL:  step <= SP_KDIV;
              SP_KDIV: begin
                kv <= rsp.res[63:0];
                step <= neg ? SP_KMUL2 : SP_EMUL;
              end
              SP_KMUL2: step <= SP_KDIV2;
              SP_KDIV2: begin
                kv <= rsp.res[63:0];
                step <= SP_EMUL;
              end
              SP_EMUL:  step <= SP_EDIV;
              SP_EDIV: begin
                ev <= rsp.res[63:0];
                if (neg) begin
                  step <= SP_EMUL2;
                end else begin
                  state <= ST_DONE;
                end
              end
              SP_EMUL2: step <= SP_EDIV2;
              SP_EDIV2: begin
                ev <= rsp.res[63:0];
                state <= ST_DONE;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_k <= not_conv ? 64'd0 : kv;
            out_e <= not_conv ? 64'd0 : ev;
            out_inf <= k_inf;
            out_nc <= not_conv;
            m_axis_tvalid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = state == ST_IDLE;
  assign m_axis_tdata = {out_e[31:0], out_k[31:0]};
  assign m_axis_tuser = {out_nc, out_inf};

endmodule

[dv/tb_top.sv]
// self-checking testbench for the elliptic integral agm block
`timescale 1ns / 1ps

module tb_top;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [31:0] k_value;
    logic [31:0] e_value;
    logic        k_infinite;
    logic        not_converged;
  } integral_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = eia_pkg::CFG_ITER_LIMIT;
  logic [30:0] cfg_data = '0;

  logic [31:0] param_queue[$];
  integral_t   expected_integrals[$];
  logic [4:0]  iter_limit = 5'd16;
  logic [30:0] conv_limit = 31'd1;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;
  int          words_checked = 0;
  int          words_infinite = 0;
  int          words_unconverged = 0;

  elliptic_integral_agm dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [127:0] wide_mul(logic [63:0] x, logic [63:0] y);
    return {64'b0, x} * {64'b0, y};
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
      t = r | (64'd1 << bit_pos);
      if (wide_mul(t, t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_div(logic [127:0] n, logic [63:0] d,
                                          logic [63:0] maxq);
    logic [127:0] q;
    if (d == 0) return maxq;
    q = n / {64'b0, d};
    return (q > {64'b0, maxq}) ? maxq : q[63:0];
  endfunction

  function automatic integral_t agm_integrals(logic [31:0] m);
    integral_t   res;
    logic        neg;
    logic        done;
    logic [63:0] mag, den, da, sq, a, b, c, s, t, term, kv, ev, rest;
    int          lim;
    res = '0;
    neg = m[31];
    sq = ONE_Q30;
    done = 1'b0;
    if (!neg && {32'b0, m} >= ONE_Q30) begin
      res.k_value = 32'hFFFF_FFFF;
      res.k_infinite = 1'b1;
      return res;
    end
    if (neg) begin
      mag = (64'd1 << 32) - {32'b0, m};
      den = ONE_Q30 + mag;
      da = sat_div(wide_mul(mag, ONE_Q30), den, eia_pkg::ALL_ONES);
      sq = floor_sqrt(wide_mul(den, ONE_Q30));
    end else begin
      da = {32'b0, m};
    end
    if (da > ONE_Q30) da = ONE_Q30;
    a = ONE_Q30;
    b = floor_sqrt(wide_mul(ONE_Q30 - da, ONE_Q30));
    c = floor_sqrt(wide_mul(da, ONE_Q30));
    s = 64'(wide_mul(c, c) >> 31);
    lim = (iter_limit < 16) ? int'(iter_limit) : 16;
    for (int i = 0; i < lim; i++) begin
      t = (a >> 1) + (b >> 1) + (a & b & 64'd1);
      c = (a >= b) ? (a - b) >> 1 : 64'd0;
      b = floor_sqrt(wide_mul(a, b));
      a = t;
      term = 64'(wide_mul(c, c) >> 30);
      term = (term > (eia_pkg::ALL_ONES >> i)) ? eia_pkg::ALL_ONES : term << i;
      s = (s > eia_pkg::ALL_ONES - term) ? eia_pkg::ALL_ONES : s + term;
      if (wide_mul(c, ONE_Q30) < wide_mul({33'b0, conv_limit}, a)) begin
        done = 1'b1;
        break;
      end
    end
    if (!done) begin
      res.not_converged = 1'b1;
      return res;
    end
    rest = (s < ONE_Q30) ? ONE_Q30 - s : 64'd0;
    if (neg) begin
      kv = sat_div(wide_mul(eia_pkg::PI_HALF_Q28, ONE_Q30), a, eia_pkg::ALL_ONES);
      kv = sat_div(wide_mul(kv, ONE_Q30), sq, eia_pkg::OUT_MAX);
      ev = sat_div(wide_mul(eia_pkg::PI_HALF_Q28, rest), a, eia_pkg::ALL_ONES);
      ev = sat_div(wide_mul(ev, sq), ONE_Q30, eia_pkg::OUT_MAX);
    end else begin
      kv = sat_div(wide_mul(eia_pkg::PI_HALF_Q28, ONE_Q30), a, eia_pkg::OUT_MAX);
      ev = sat_div(wide_mul(eia_pkg::PI_HALF_Q28, rest), a, eia_pkg::OUT_MAX);
    end
    res.k_value = kv[31:0];
    res.e_value = ev[31:0];
    return res;
  endfunction

  // driver: input side, predicts on each accepted word
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_integrals.push_back(agm_integrals(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (param_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= param_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: output side
  always @(posedge clk) begin
    integral_t got;
    integral_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_integrals.size() == 0) begin
          errors++;
          $display("%0t: unexpected word k=%h e=%h flags=%b", $time,
                   got.k_value, got.e_value, m_axis_tuser);
        end else begin
          want = expected_integrals.pop_front();
          words_checked++;
          if (want.k_infinite) words_infinite++;
          if (want.not_converged) words_unconverged++;
          if (got.k_value !== want.k_value) begin
            errors++;
            $display("%0t: k_value expected %h actual %h", $time, want.k_value, got.k_value);
          end
          if (got.e_value !== want.e_value) begin
            errors++;
            $display("%0t: e_value expected %h actual %h", $time, want.e_value, got.e_value);
          end
          if (got.k_infinite !== want.k_infinite) begin
            errors++;
            $display("%0t: k_infinite expected %b actual %b", $time,
                     want.k_infinite, got.k_infinite);
          end
          if (got.not_converged !== want.not_converged) begin
            errors++;
            $display("%0t: not_converged expected %b actual %b", $time,
                     want.not_converged, got.not_converged);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == eia_pkg::CFG_ITER_LIMIT) iter_limit = value[4:0];
    else conv_limit = value;
  endtask

  task automatic drain;
    while (param_queue.size() > 0 || s_axis_tvalid || expected_integrals.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] random_param;
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    if (sel < 8) return $urandom_range(32'h4000_0000 - 1, 32'h3FF0_0000);
    return $urandom;
  endfunction

  task automatic run_phase(logic [4:0] iters, logic [30:0] conv, int idle, int stall,
                           int count);
    write_reg(eia_pkg::CFG_ITER_LIMIT, {26'b0, iters});
    write_reg(eia_pkg::CFG_CONV_LIMIT, conv);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) param_queue.push_back(random_param());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed corners at reset settings
    param_queue = '{32'h0000_0000, 32'h4000_0000, 32'h7FFF_FFFF, 32'hC000_0000,
                    32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h3FFF_FFFF,
                    32'h2000_0000, 32'hE000_0000, 32'h4000_0001, 32'hFFFF_FFFE};
    drain();
    run_phase(5'd16, 31'd1, 0, 0, 150);
    run_phase(5'd1, 31'h4000_0000, 80, 0, 150);
    run_phase(5'd0, 31'h7FFF_FFFF, 0, 80, 80);
    run_phase(5'd31, 31'd0, 36, 36, 80);
    run_phase(5'd16, 31'd1000, 0, 0, 150);
    run_phase(5'($urandom_range(16, 1)), 31'($urandom_range(32'h4000_0000)), 36, 36, 200);
    run_phase(5'($urandom_range(16, 1)), 31'($urandom_range(32'h10_0000)), 0, 0, 200);
    repeat (100) @(posedge clk);
    $display("checked %0d words (%0d infinite, %0d unconverged) over eight register settings",
             words_checked, words_infinite, words_unconverged);
    $display("with sender idling and receiver stalling in varied mixes");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
hdl/eia_pkg.sv
hdl/eia_unit.sv
hdl/elliptic_integral_agm.sv
dv/tb_top.sv
